// File: design/s2d_pkg.sv
// ----------------------------------------------------------------------------
// s2d_pkg
// Shared constants and types for the signed integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package s2d_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 6;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int CNT_W      = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ     = 4'd3;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_FIND = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage

// File: design/s2d_cell.sv
// ----------------------------------------------------------------------------
// s2d_cell
// One BCD digit of the shift-and-add-3 converter.
// ----------------------------------------------------------------------------
module s2d_cell (
  input  logic            clk,
  input  logic            clr,
  input  logic            shift,
  input  logic            bit_in,
  output s2d_pkg::digit_t digit,
  output logic            carry_out
);

  s2d_pkg::digit_t digit_r;
  s2d_pkg::digit_t adj;

  always_comb begin
    if (digit_r >= s2d_pkg::BCD_ADJ_MIN) begin
      adj = digit_r + s2d_pkg::BCD_ADJ;
    end else begin
      adj = digit_r;
    end
  end

  assign carry_out = adj[s2d_pkg::DIGIT_W-1];
  assign digit     = digit_r;

  always_ff @(posedge clk) begin
    if (clr) begin
      digit_r <= '0;
    end else if (shift) begin
      digit_r <= {adj[s2d_pkg::DIGIT_W-2:0], bit_in};
    end
  end

endmodule

// File: design/s2d_chain.sv
// ----------------------------------------------------------------------------
// s2d_chain
// Row of BCD digit cells; binary bits enter at the least significant cell.
// ----------------------------------------------------------------------------
module s2d_chain (
  input  logic            clk,
  input  logic            clr,
  input  logic            shift,
  input  logic            bit_in,
  output s2d_pkg::digit_t digits [s2d_pkg::NUM_DIGITS]
);

  logic carry [s2d_pkg::NUM_DIGITS+1];

  assign carry[0] = bit_in;

  for (genvar i = 0; i < s2d_pkg::NUM_DIGITS; i++) begin : g_cell
    s2d_cell u_cell (
      .clk       (clk),
      .clr       (clr),
      .shift     (shift),
      .bit_in    (carry[i]),
      .digit     (digits[i]),
      .carry_out (carry[i+1])
    );
  end

endmodule

// File: design/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to decimal ASCII text, one character
// per transfer, most significant first, minus sign leading when negative.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   in      | in_valid, in_stall, in_value[31:0]     | consumer
//   out     | out_valid, out_stall, out_char_code,   | producer
//           | out_last_char                          |
//
// One item passes through an accept step, a shift phase that moves the 32
// magnitude bits through the digit cell row, a step to locate the leading
// digit, then 1 to 11 characters at one per cycle while the output does not
// stall. Output stalls stretch the character phase. in_stall stays high from
// accept until the last character is loaded into the output register. Reset
// empties the output register and returns to idle.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [5:0]                  out_char_code,
  output logic                        out_last_char
);

  s2d_pkg::state_t                     state_r, state_nxt;
  logic [s2d_pkg::VALUE_W-1:0]         mag_r, mag_nxt;
  logic                                neg_r, neg_nxt;
  logic [s2d_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [s2d_pkg::IDX_W-1:0]           idx_r, idx_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [s2d_pkg::CHAR_W-1:0]          char_r, char_nxt;
  logic                                last_r, last_nxt;

  s2d_pkg::digit_t                     digits [s2d_pkg::NUM_DIGITS];
  logic [s2d_pkg::IDX_W-1:0]           lead_idx;
  logic                                in_xfer;
  logic                                out_free;
  logic                                conv_shift;
  s2d_pkg::digit_t                     cur_digit;

  assign in_stall      = (state_r != s2d_pkg::ST_IDLE);
  assign in_xfer       = in_valid && !in_stall;
  assign out_free      = !out_valid_r || !out_stall;
  assign conv_shift    = (state_r == s2d_pkg::ST_CONV);
  assign out_valid     = out_valid_r;
  assign out_char_code = char_r;
  assign out_last_char = last_r;
  assign cur_digit     = digits[idx_r];

  s2d_chain u_chain (
    .clk    (clk),
    .clr    (in_xfer),
    .shift  (conv_shift),
    .bit_in (mag_r[s2d_pkg::VALUE_W-1]),
    .digits (digits)
  );

  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < s2d_pkg::NUM_DIGITS; i++) begin
      if (digits[i] != '0) begin
        lead_idx = s2d_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;

    if (out_free) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      s2d_pkg::ST_IDLE: begin
        if (in_xfer) begin
          neg_nxt   = in_value[s2d_pkg::VALUE_W-1];
          mag_nxt   = in_value[s2d_pkg::VALUE_W-1] ? (~in_value + 1'b1) : in_value;
          cnt_nxt   = '0;
          state_nxt = s2d_pkg::ST_CONV;
        end
      end
      s2d_pkg::ST_CONV: begin
        mag_nxt = {mag_r[s2d_pkg::VALUE_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == s2d_pkg::CNT_W'(s2d_pkg::VALUE_W - 1)) begin
          state_nxt = s2d_pkg::ST_FIND;
        end
      end
      s2d_pkg::ST_FIND: begin
        idx_nxt   = lead_idx;
        state_nxt = s2d_pkg::ST_EMIT;
      end
      s2d_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (neg_r) begin
            char_nxt = s2d_pkg::CHAR_MINUS;
            last_nxt = 1'b0;
            neg_nxt  = 1'b0;
          end else begin
            char_nxt = s2d_pkg::CHAR_ZERO + s2d_pkg::CHAR_W'(cur_digit);
            last_nxt = (idx_r == '0);
            if (idx_r == '0) begin
              state_nxt = s2d_pkg::ST_IDLE;
            end else begin
              idx_nxt = idx_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = s2d_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= s2d_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

endmodule

// File: tb/tb_signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii
// Feeds signed 32-bit values to the converter and checks every character
// transfer, code and last flag, against decimal text predicted from each
// accepted value. Covers edge values, random magnitudes, random input gaps,
// random output stalls, back-to-back traffic and pauses until drained.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;

  typedef struct packed {
    logic [s2d_pkg::CHAR_W-1:0] code;
    logic                       last;
  } text_char_t;

  logic                               clk;
  logic                               rst_n         = 1'b0;
  logic                               in_valid      = 1'b0;
  logic                               in_stall;
  logic signed [s2d_pkg::VALUE_W-1:0] in_value      = '0;
  logic                               out_valid;
  logic                               out_stall     = 1'b0;
  logic [s2d_pkg::CHAR_W-1:0]         out_char_code;
  logic                               out_last_char;

  text_char_t expected_text[$];
  int         mismatches = 0;
  bit         stall_en   = 1'b1;
  int         stall_left = 0;

  signed_int_to_decimal_ascii i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic predict_text(input logic [s2d_pkg::VALUE_W-1:0] value);
    logic [s2d_pkg::VALUE_W:0] mag;
    s2d_pkg::digit_t           digits [s2d_pkg::NUM_DIGITS];
    int                        nd;
    text_char_t                c;
    mag = value[s2d_pkg::VALUE_W-1] ? -{1'b1, value} : {1'b0, value};
    nd  = 0;
    do begin
      digits[nd] = s2d_pkg::digit_t'(mag % 10);
      mag        = mag / 10;
      nd++;
    end while (mag != 0);
    if (value[s2d_pkg::VALUE_W-1]) begin
      c.code = s2d_pkg::CHAR_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      c.code = s2d_pkg::CHAR_ZERO + digits[k];
      c.last = (k == 0);
      expected_text.push_back(c);
    end
  endtask

  // predict on every input transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) predict_text(in_value);
  end

  always @(posedge clk) begin : check_chars
    text_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected character code %0d", out_char_code));
      end else begin
        want = expected_text.pop_front();
        if (out_char_code !== want.code)
          report_mismatch($sformatf("char code %0d, want %0d", out_char_code, want.code));
        if (out_last_char !== want.last)
          report_mismatch($sformatf("last flag %b, want %b", out_last_char, want.last));
      end
    end
  end

  // hold stall for random stretches
  always @(posedge clk) begin
    int pick;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!stall_en) begin
      out_stall <= 1'b0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else if (pick < 93) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(5, 40);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [s2d_pkg::VALUE_W-1:0] random_value();
    logic [s2d_pkg::VALUE_W-1:0] v;
    longint unsigned             scale;
    int                          kind;
    kind  = $urandom_range(0, 3);
    scale = 1;
    repeat ($urandom_range(1, 9)) scale = scale * 10;
    case (kind)
      0:       v = $urandom;
      1:       v = $urandom_range(0, 20);
      2:       v = s2d_pkg::VALUE_W'(scale) - $urandom_range(0, 1);
      default: v = s2d_pkg::VALUE_W'($urandom % scale);
    endcase
    if (kind != 0 && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic send_value(input logic [s2d_pkg::VALUE_W-1:0] value, input bit gaps);
    int idle;
    idle = gaps ? pick_gap() : 0;
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid, then hold until every character has been checked
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_text.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic test_directed();
    int vals [] = '{0, 1, -1, 9, 10, -10, 99, 100, -101, 999999999, 1000000000,
                    -1000000000, 2147483647, -2147483647, 32'h8000_0000, 123456789,
                    -987654321, 32'h5555_5555, 32'hAAAA_AAAA, 7, -7};
    foreach (vals[i]) send_value(vals[i], i > 10);
  endtask

  task automatic test_random_values();
    repeat (60) begin
      send_value(random_value(), 1'b1);
      if ($urandom_range(0, 14) == 0) wait_drained();
    end
  endtask

  task automatic test_back_to_back();
    stall_en <= 1'b0;
    repeat (40) send_value(random_value(), 1'b0);
    wait_drained();
    stall_en <= 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_random_values();
    wait_drained();
    test_back_to_back();
    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
